[hdl/median_ratio_channel_normalizer_macros.svh]
// Assertion macros shared by the normalizer RTL.
`ifndef MEDIAN_RATIO_CHANNEL_NORMALIZER_MACROS_SVH
`define MEDIAN_RATIO_CHANNEL_NORMALIZER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MRCN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("normalizer assertion failed");

// Next-cycle implication, checked outside reset.
`define MRCN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("normalizer assertion failed");

`endif

[hdl/mrcn_pkg.sv]
// Types, constants and helpers of the median ratio channel normalizer.
package mrcn_pkg;

  localparam int CHANNELS   = 16;
  localparam int MAX_RATIOS = 1024;
  localparam int CH_W   = $clog2(CHANNELS);
  localparam int IDX_W  = $clog2(MAX_RATIOS);
  localparam int CNT_W  = $clog2(MAX_RATIOS + 1);
  localparam int ADDR_W = CH_W + IDX_W;
  localparam int N_W    = $clog2(CHANNELS + 1);

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] SAT_Q16 = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_FACTOR = 2'd1,
    FN_NORM   = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOREF = 2'd3
  } status_t;

  typedef enum logic {
    CFG_CHANNEL_COUNT = 1'b0,
    CFG_REFERENCE     = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_DIV,
    S_LOAD_WR,
    S_NORM_DIV,
    S_FAC_START,
    S_SEL_SCAN,
    S_SEL_DECIDE
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [3:0]  channel;
    logic [31:0] intensity;
    logic [31:0] reference_level;
    logic        feature_has_reference;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  out_channel;
    logic        is_factor;
    logic        last;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] quot;
  } div_res_t;

  function automatic logic [N_W-1:0] used_channels(input logic [4:0] cc);
    logic [N_W-1:0] n;
    if (cc < 5'd2) begin
      n = N_W'(2);
    end else if (32'(cc) > CHANNELS) begin
      n = N_W'(CHANNELS);
    end else begin
      n = N_W'(cc);
    end
    return n;
  endfunction

endpackage

[hdl/mrcn_div.sv]
// Radix-2 restoring divider for floor((num << 16) / den), saturating.
module mrcn_div import mrcn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output div_res_t    res
);

  logic [31:0] rem;
  logic [31:0] shf;
  logic [31:0] quot;
  logic [31:0] dsr;
  logic [5:0]  steps;
  logic        run;
  logic        sat;
  logic        done;
  logic [32:0] trial;
  logic        take;

  assign trial = {rem, shf[31]};
  assign take  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        steps <= 6'd0;
        // quotient overflows when num >= den * 2^16
        sat   <= (den[31:16] == 16'd0) && (num[31:16] >= den[15:0]);
        rem   <= {16'd0, num[31:16]};
        shf   <= {num[15:0], 16'd0};
        dsr   <= den;
        quot  <= 32'd0;
      end else if (run) begin
        shf   <= {shf[30:0], 1'b0};
        quot  <= {quot[30:0], take};
        rem   <= take ? 32'(trial - {1'b0, dsr}) : trial[31:0];
        steps <= steps + 6'd1;
        if (steps == 6'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.sat  = sat;
  assign res.quot = quot;

endmodule

[hdl/mrcn_ratio_ram.sv]
// Ratio list memory: one write port, one registered read port.
module mrcn_ratio_ram import mrcn_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [CHANNELS*MAX_RATIOS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/median_ratio_channel_normalizer.sv]
// Top level of the median ratio channel normalizer.
// Commands enter on start/item and are taken when start is high and busy low.
// func 0 loads one ratio intensity/reference into the channel's list in the
// ratio memory through the serial divider, or a saturated ratio when only the
// reference is zero; no transaction.
// func 2 normalizes one element: one result_valid transaction in the cycle
// after its accept, or once the serial divider is done when it is needed.
// func 1 emits one factor per channel in use, last set on the final one.
// Each channel's upper median is found by a radix select: 32 passes over its
// list in the memory, one entry read a cycle; an empty channel gets no scan.
// The single read port of the ratio memory sets the factor run length,
// the one-bit-a-cycle divider sets the load and normalize latency.
// Results are strobed on result_valid for one cycle; the receiver cannot
// stall, so each transaction must be taken when shown.
// Reset clears the list counts, sets all factors to 1.0 and the registers to
// four channels with reference channel 0. The memory needs no clearing.
// Configuration writes are taken at any edge with cfg_write high.
module median_ratio_channel_normalizer import mrcn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        result_valid,
  output result_t     result,
  input  logic        cfg_write,
  input  cfg_index_t  cfg_index,
  input  logic [4:0]  cfg_data
);

`include "median_ratio_channel_normalizer_macros.svh"

  state_t state, state_next;

  logic [4:0]       channel_count;
  logic [3:0]       reference_channel;
  logic [CNT_W-1:0] ratio_count [CHANNELS];
  logic [31:0]      factor_table [CHANNELS];

  logic [N_W-1:0]   n_used;
  logic             accept;
  logic             ch_in_use;
  logic [CH_W-1:0]  in_ch;

  logic [3:0]       lch;
  logic [31:0]      ratio;

  logic [CH_W-1:0]  sel_ch;
  logic [CNT_W-1:0] cnt_cur;
  logic [CNT_W-1:0] sel_k;
  logic [CNT_W-1:0] zero_cnt;
  logic [CNT_W-1:0] idx;
  logic [31:0]      prefix;
  logic [31:0]      mask;
  logic [4:0]       bitpos;
  logic             rd_valid;
  logic             sel_last;

  logic             div_start;
  logic [31:0]      div_num;
  logic [31:0]      div_den;
  div_res_t         div_res;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;
  logic              hit_zero;
  logic [31:0]       bit_one;

  assign n_used    = used_channels(channel_count);
  assign accept    = start && !busy;
  assign in_ch     = item.channel[CH_W-1:0];
  assign ch_in_use = N_W'(item.channel) < n_used;
  assign sel_last  = (N_W'(sel_ch) + N_W'(1)) == n_used;
  assign bit_one   = 32'd1 << bitpos;
  assign hit_zero  = (((ram_rdata ^ prefix) & mask) == 32'd0) && !ram_rdata[bitpos];

  mrcn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  mrcn_ratio_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ratio),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (item.func)
            FN_LOAD: begin
              if (item.feature_has_reference && ch_in_use) begin
                if (item.reference_level != 32'd0) begin
                  state_next = S_LOAD_DIV;
                end else if (item.intensity != 32'd0) begin
                  state_next = S_LOAD_WR;
                end
              end
            end
            FN_FACTOR: state_next = S_FAC_START;
            FN_NORM: begin
              if (item.feature_has_reference &&
                  !(item.channel == reference_channel && ch_in_use) &&
                  factor_table[in_ch] != 32'd0) begin
                state_next = S_NORM_DIV;
              end
            end
            FN_NOP: state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD_DIV:  if (div_res.done) state_next = S_LOAD_WR;
      S_LOAD_WR:   state_next = S_IDLE;
      S_NORM_DIV:  if (div_res.done) state_next = S_IDLE;
      S_FAC_START: begin
        if (ratio_count[sel_ch] != '0) begin
          state_next = S_SEL_SCAN;
        end else if (sel_last) begin
          state_next = S_IDLE;
        end
      end
      S_SEL_SCAN:  if (idx == cnt_cur && !rd_valid) state_next = S_SEL_DECIDE;
      S_SEL_DECIDE: begin
        if (bitpos != 5'd0) begin
          state_next = S_SEL_SCAN;
        end else if (sel_last) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_FAC_START;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and control strobes
  always_comb begin
    busy      = state != S_IDLE;
    div_start = 1'b0;
    div_num   = item.intensity;
    div_den   = (item.func == FN_LOAD) ? item.reference_level : factor_table[in_ch];
    ram_we    = 1'b0;
    ram_waddr = {lch[CH_W-1:0], ratio_count[lch[CH_W-1:0]][IDX_W-1:0]};
    ram_re    = 1'b0;
    ram_raddr = {sel_ch, idx[IDX_W-1:0]};
    unique case (state)
      S_IDLE:     div_start = accept && (state_next == S_LOAD_DIV || state_next == S_NORM_DIV);
      S_LOAD_WR:  ram_we = ratio_count[lch[CH_W-1:0]] < CNT_W'(MAX_RATIOS);
      S_SEL_SCAN: ram_re = idx < cnt_cur;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      channel_count     <= 5'd4;
      reference_channel <= 4'd0;
      result_valid      <= 1'b0;
      rd_valid          <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        ratio_count[c]  <= '0;
        factor_table[c] <= ONE_Q16;
      end
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      rd_valid     <= ram_re;

      if (cfg_write) begin
        unique case (cfg_index)
          CFG_CHANNEL_COUNT: channel_count     <= cfg_data;
          CFG_REFERENCE:     reference_channel <= cfg_data[3:0];
        endcase
      end

      unique case (state)
        S_IDLE: begin
          lch    <= item.channel;
          ratio  <= SAT_Q16;
          sel_ch <= '0;
          if (accept && item.func == FN_NORM && state_next == S_IDLE) begin
            result_valid       <= 1'b1;
            result.out_channel <= item.channel;
            result.is_factor   <= 1'b0;
            result.last        <= 1'b0;
            if (!item.feature_has_reference) begin
              result.value  <= item.intensity;
              result.status <= ST_NOREF;
            end else if (item.channel == reference_channel && ch_in_use) begin
              result.value  <= ONE_Q16;
              result.status <= ST_OK;
            end else if (item.intensity == 32'd0) begin
              result.value  <= 32'd0;
              result.status <= ST_OK;
            end else begin
              result.value  <= SAT_Q16;
              result.status <= ST_SAT;
            end
          end
        end
        S_LOAD_DIV: begin
          if (div_res.done) ratio <= div_res.sat ? SAT_Q16 : div_res.quot;
        end
        S_LOAD_WR: begin
          if (ram_we) begin
            ratio_count[lch[CH_W-1:0]] <= ratio_count[lch[CH_W-1:0]] + CNT_W'(1);
          end
        end
        S_NORM_DIV: begin
          if (div_res.done) begin
            result_valid       <= 1'b1;
            result.out_channel <= lch;
            result.is_factor   <= 1'b0;
            result.last        <= 1'b0;
            result.value       <= div_res.sat ? SAT_Q16 : div_res.quot;
            result.status      <= div_res.sat ? ST_SAT : ST_OK;
          end
        end
        S_FAC_START: begin
          cnt_cur  <= ratio_count[sel_ch];
          sel_k    <= ratio_count[sel_ch] >> 1;
          prefix   <= 32'd0;
          mask     <= 32'd0;
          bitpos   <= 5'd31;
          idx      <= '0;
          zero_cnt <= '0;
          if (ratio_count[sel_ch] == '0) begin
            factor_table[sel_ch] <= ONE_Q16;
            result_valid         <= 1'b1;
            result.value         <= ONE_Q16;
            result.out_channel   <= 4'(sel_ch);
            result.is_factor     <= 1'b1;
            result.last          <= sel_last;
            result.status        <= ST_EMPTY;
            sel_ch               <= sel_ch + CH_W'(1);
          end
        end
        S_SEL_SCAN: begin
          if (ram_re) idx <= idx + CNT_W'(1);
          if (rd_valid && hit_zero) zero_cnt <= zero_cnt + CNT_W'(1);
        end
        S_SEL_DECIDE: begin
          logic [31:0] pfx;
          pfx = (sel_k < zero_cnt) ? prefix : (prefix | bit_one);
          if (sel_k >= zero_cnt) sel_k <= sel_k - zero_cnt;
          prefix   <= pfx;
          mask     <= mask | bit_one;
          bitpos   <= bitpos - 5'd1;
          idx      <= '0;
          zero_cnt <= '0;
          if (bitpos == 5'd0) begin
            factor_table[sel_ch] <= pfx;
            ratio_count[sel_ch]  <= '0;
            result_valid         <= 1'b1;
            result.value         <= pfx;
            result.out_channel   <= 4'(sel_ch);
            result.is_factor     <= 1'b1;
            result.last          <= sel_last;
            result.status        <= ST_OK;
            sel_ch               <= sel_ch + CH_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  `MRCN_ASSERT_NOW(a_last_is_factor, result_valid && result.last, result.is_factor)
  `MRCN_ASSERT_NOW(a_norm_fields, result_valid && !result.is_factor, !result.last && result.status != ST_EMPTY)
  `MRCN_ASSERT_NOW(a_zero_bound, state == S_SEL_DECIDE, zero_cnt <= cnt_cur)
  `MRCN_ASSERT_NEXT(a_factor_busy, accept && item.func == FN_FACTOR, busy)

endmodule
